// File: rtl/imsu_pkg.sv
// ----------------------------------------------------------------------------
// imsu_pkg
// Shared types and constants of the Ising Metropolis site-update engine.
// ----------------------------------------------------------------------------
package imsu_pkg;

    localparam int COORD_W       = 4;
    localparam int SIZE_W        = 5;
    localparam int ENTRY_W       = 5;
    localparam int VALUE_W       = 17;
    localparam int FRAC_W        = 16;
    localparam int SUM_W         = 4;
    localparam int STATUS_W      = 2;
    localparam int CMD_W         = 2;
    localparam int CFG_IDX_W     = 2;
    localparam int TABLE_DEPTH   = 26;
    localparam int SIDE_MAX_DEF  = 16;
    localparam int RAND_BITS_DEF = 16;

    localparam int FIX_W = 3 * COORD_W + 1 + ENTRY_W + VALUE_W;
    localparam int OUT_W = 1 + 1 + SUM_W + STATUS_W;

    localparam logic [VALUE_W-1:0] ONE_Q16 = 17'h10000;

    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Z = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WRAP   = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_SITE  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_ENTRY = 2'd2;

    typedef enum logic [CMD_W-1:0] {
        CMD_WRITE   = 2'd0,
        CMD_READ    = 2'd1,
        CMD_LOAD    = 2'd2,
        CMD_ATTEMPT = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        STEP_CTR = 3'd0,
        STEP_XP  = 3'd1,
        STEP_YP  = 3'd2,
        STEP_ZP  = 3'd3,
        STEP_XM  = 3'd4,
        STEP_YM  = 3'd5,
        STEP_ZM  = 3'd6
    } t_step;

    typedef struct packed {
        logic [SIZE_W-1:0] size_x;
        logic [SIZE_W-1:0] size_y;
        logic [SIZE_W-1:0] size_z;
        logic              wrap;
    } t_cfg;

endpackage

// File: rtl/imsu_nbr_step.sv
// ----------------------------------------------------------------------------
// imsu_nbr_step
// Site address unit: clamps lattice extents, checks the addressed site and
// forms the spin address of the centre or of one of its six neighbours.
// ----------------------------------------------------------------------------
module imsu_nbr_step #(
    parameter int SIDE_MAX = imsu_pkg::SIDE_MAX_DEF
) (
    input  imsu_pkg::t_cfg                  i_cfg,
    input  logic [imsu_pkg::COORD_W-1:0]    i_x,
    input  logic [imsu_pkg::COORD_W-1:0]    i_y,
    input  logic [imsu_pkg::COORD_W-1:0]    i_z,
    input  imsu_pkg::t_step                 i_step,
    output logic                            o_in_range,
    output logic                            o_valid,
    output logic [3*$clog2(SIDE_MAX)-1:0]   o_addr
);
    import imsu_pkg::*;

    localparam int CW    = $clog2(SIDE_MAX);
    localparam int SMW   = $clog2(SIDE_MAX + 1);
    localparam int CMPW0 = (SMW > SIZE_W) ? SMW : SIZE_W;
    localparam int CMPW  = (CMPW0 > COORD_W + 1) ? CMPW0 : COORD_W + 1;

    function automatic logic [CMPW-1:0] eff_size(input logic [SIZE_W-1:0] s);
        logic [CMPW-1:0] w;
        w = CMPW'(s);
        if (s == '0) begin
            w = CMPW'(1);
        end else if (w > CMPW'(SIDE_MAX)) begin
            w = CMPW'(SIDE_MAX);
        end
        return w;
    endfunction

    logic [CMPW-1:0] nx, ny, nz;
    logic [CMPW-1:0] cx, cy, cz;
    logic [CMPW-1:0] ac, an, ar;
    logic [CMPW-1:0] rx, ry, rz;
    logic [1:0]      axis;
    logic            plus;

    assign nx = eff_size(i_cfg.size_x);
    assign ny = eff_size(i_cfg.size_y);
    assign nz = eff_size(i_cfg.size_z);
    assign cx = CMPW'(i_x);
    assign cy = CMPW'(i_y);
    assign cz = CMPW'(i_z);

    assign o_in_range = (cx < nx) && (cy < ny) && (cz < nz);

    always_comb begin
        axis = 2'd0;
        plus = 1'b1;
        unique case (i_step)
            STEP_CTR: begin axis = 2'd0; plus = 1'b1; end
            STEP_XP:  begin axis = 2'd1; plus = 1'b1; end
            STEP_YP:  begin axis = 2'd2; plus = 1'b1; end
            STEP_ZP:  begin axis = 2'd3; plus = 1'b1; end
            STEP_XM:  begin axis = 2'd1; plus = 1'b0; end
            STEP_YM:  begin axis = 2'd2; plus = 1'b0; end
            STEP_ZM:  begin axis = 2'd3; plus = 1'b0; end
            default:  begin axis = 2'd0; plus = 1'b1; end
        endcase
    end

    always_comb begin
        ac = cx;
        an = nx;
        unique case (axis)
            2'd2: begin ac = cy; an = ny; end
            2'd3: begin ac = cz; an = nz; end
            default: begin ac = cx; an = nx; end
        endcase
        o_valid = 1'b1;
        ar      = ac;
        if (axis != 2'd0) begin
            if (plus) begin
                if (ac + CMPW'(1) < an) begin
                    ar = ac + CMPW'(1);
                end else if (i_cfg.wrap) begin
                    ar = '0;
                end else begin
                    o_valid = 1'b0;
                end
            end else begin
                if (ac != '0) begin
                    ar = ac - CMPW'(1);
                end else if (i_cfg.wrap) begin
                    ar = an - CMPW'(1);
                end else begin
                    o_valid = 1'b0;
                end
            end
        end
        rx = (axis == 2'd1) ? ar : cx;
        ry = (axis == 2'd2) ? ar : cy;
        rz = (axis == 2'd3) ? ar : cz;
    end

    assign o_addr = {rz[CW-1:0], ry[CW-1:0], rx[CW-1:0]};

endmodule

// File: rtl/ising_metropolis_site_update.sv
// ----------------------------------------------------------------------------
// ising_metropolis_site_update
// Metropolis site-update engine for a 3D Ising lattice of one-bit spins.
// ----------------------------------------------------------------------------
// One command item at a time: the block takes an item, works on it, parks the
// result in an output register and is ready again while that result waits.
// Spin reads go through one single-port spin memory with registered read, so
// an attempt goes through a check step, a scan of the centre and its six
// neighbours, a drain step, a threshold lookup, a decision with write-back,
// a response step and the idle state that takes the next item.
// A read scans only the centre and has no decision; write, table load and
// out-of-range items go from the check straight to the response.
// A result that finds the previous one still waiting holds the block in its
// response cycle until the previous one is taken.
// Spin memory and threshold table hold no defined value until written.
// ----------------------------------------------------------------------------
module ising_metropolis_site_update #(
    parameter int SIDE_MAX  = imsu_pkg::SIDE_MAX_DEF,
    parameter int RAND_BITS = imsu_pkg::RAND_BITS_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // cfg: index 0 size_x, 1 size_y, 2 size_z, 3 wrap_mode
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [imsu_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [imsu_pkg::SIZE_W-1:0]            i_cfg_data,
    input  logic                                   i_s_tvalid,
    output logic                                   o_s_tready,
    // site_x, site_y, site_z, spin_in, entry_index, entry_value, random_fraction
    input  logic [((imsu_pkg::FIX_W+RAND_BITS+7)/8)*8-1:0] i_s_tdata,
    // command
    input  logic [imsu_pkg::CMD_W-1:0]             i_s_tuser,
    output logic                                   o_m_tvalid,
    input  logic                                   i_m_tready,
    // spin_out, flipped, neighbour_sum, status
    output logic [imsu_pkg::OUT_W-1:0]             o_m_tdata
);
    import imsu_pkg::*;

    localparam int CW      = $clog2(SIDE_MAX);
    localparam int AW      = 3 * CW;
    localparam int DEPTH   = 1 << AW;
    localparam int CMP_W   = RAND_BITS + VALUE_W;
    localparam int OFF_Y   = COORD_W;
    localparam int OFF_Z   = 2 * COORD_W;
    localparam int OFF_S   = 3 * COORD_W;
    localparam int OFF_E   = OFF_S + 1;
    localparam int OFF_V   = OFF_E + ENTRY_W;

    typedef enum logic [2:0] {
        S_IDLE, S_CHECK, S_SCAN, S_DRAIN, S_LOOKUP, S_DECIDE, S_RESP
    } t_state;

    t_state                 r_state;
    t_step                  r_k, n_k, r_rd_k, step_sel;
    t_cmd                   r_cmd;
    t_cfg                   r_cfg;
    logic [COORD_W-1:0]     r_x, r_y, r_z;
    logic                   r_spin_in;
    logic [ENTRY_W-1:0]     r_eidx;
    logic [VALUE_W-1:0]     r_evalue;
    logic [RAND_BITS-1:0]   r_rnd;
    logic                   r_self;
    logic signed [SUM_W-1:0] r_sum;
    logic                   r_rd_pend;
    logic [VALUE_W-1:0]     r_thr;
    logic                   r_res_spin, r_res_flip;
    logic [STATUS_W-1:0]    r_res_status;
    logic                   r_out_valid, r_out_spin, r_out_flip;
    logic [SUM_W-1:0]       r_out_sum;
    logic [STATUS_W-1:0]    r_out_status;
    logic                   r_rd_data;
    logic                   r_mem [DEPTH];
    logic [VALUE_W-1:0]     r_table [TABLE_DEPTH];

    logic                   in_range, nbr_valid;
    logic [AW-1:0]          mem_addr;
    logic                   mem_we, mem_wd, tab_we, flip;
    logic [VALUE_W-1:0]     sat_value;
    logic [ENTRY_W-1:0]     tab_idx;
    logic [CMP_W-1:0]       cmp_r, cmp_t;

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = (r_state == S_IDLE);
    assign o_m_tvalid  = r_out_valid;
    assign o_m_tdata   = {r_out_status, r_out_sum, r_out_flip, r_out_spin};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.size_x <= SIZE_W'(16);
            r_cfg.size_y <= SIZE_W'(16);
            r_cfg.size_z <= SIZE_W'(16);
            r_cfg.wrap   <= 1'b1;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_SIZE_X: r_cfg.size_x <= i_cfg_data;
                CFG_SIZE_Y: r_cfg.size_y <= i_cfg_data;
                CFG_SIZE_Z: r_cfg.size_z <= i_cfg_data;
                CFG_WRAP:   r_cfg.wrap   <= i_cfg_data[0];
                default:    r_cfg.wrap   <= r_cfg.wrap;
            endcase
        end
    end

    assign step_sel = (r_state == S_SCAN) ? r_k : STEP_CTR;
    assign n_k      = t_step'(3'(r_k) + 3'd1);

    imsu_nbr_step #(
        .SIDE_MAX (SIDE_MAX)
    ) u_nbr (
        .i_cfg      (r_cfg),
        .i_x        (r_x),
        .i_y        (r_y),
        .i_z        (r_z),
        .i_step     (step_sel),
        .o_in_range (in_range),
        .o_valid    (nbr_valid),
        .o_addr     (mem_addr)
    );

    assign cmp_r  = {1'b0, r_rnd, {FRAC_W{1'b0}}};
    assign cmp_t  = {r_thr, {RAND_BITS{1'b0}}};
    assign flip   = (cmp_r < cmp_t);

    assign mem_we = ((r_state == S_CHECK) && (r_cmd == CMD_WRITE) && in_range)
                 || ((r_state == S_DECIDE) && flip);
    assign mem_wd = (r_state == S_CHECK) ? r_spin_in : ~r_self;

    assign tab_we    = (r_state == S_CHECK) && (r_cmd == CMD_LOAD)
                    && (r_eidx < ENTRY_W'(TABLE_DEPTH));
    assign sat_value = (r_evalue > ONE_Q16) ? ONE_Q16 : r_evalue;
    assign tab_idx   = {r_sum[SUM_W-1], r_sum} + (r_self ? 5'd19 : 5'd6);

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_addr] <= mem_wd;
        end
        r_rd_data <= r_mem[mem_addr];
    end

    always_ff @(posedge i_clk) begin
        if (tab_we) begin
            r_table[r_eidx] <= sat_value;
        end
        r_thr <= r_table[tab_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_rd_pend   <= 1'b0;
        end else begin
            if (r_out_valid && i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            r_rd_pend <= 1'b0;
            if (r_rd_pend) begin
                if (r_rd_k == STEP_CTR) begin
                    r_self <= r_rd_data;
                end else begin
                    r_sum <= r_sum + (r_rd_data ? 4'sd1 : -4'sd1);
                end
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_s_tvalid) begin
                        r_cmd     <= t_cmd'(i_s_tuser);
                        r_x       <= i_s_tdata[0 +: COORD_W];
                        r_y       <= i_s_tdata[OFF_Y +: COORD_W];
                        r_z       <= i_s_tdata[OFF_Z +: COORD_W];
                        r_spin_in <= i_s_tdata[OFF_S];
                        r_eidx    <= i_s_tdata[OFF_E +: ENTRY_W];
                        r_evalue  <= i_s_tdata[OFF_V +: VALUE_W];
                        r_rnd     <= i_s_tdata[FIX_W +: RAND_BITS];
                        r_state   <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    r_sum        <= '0;
                    r_res_spin   <= 1'b0;
                    r_res_flip   <= 1'b0;
                    r_res_status <= ST_OK;
                    r_k          <= STEP_CTR;
                    if (r_cmd == CMD_LOAD) begin
                        if (!tab_we) begin
                            r_res_status <= ST_ENTRY;
                        end
                        r_state <= S_RESP;
                    end else if (!in_range) begin
                        r_res_status <= ST_SITE;
                        r_state      <= S_RESP;
                    end else if (r_cmd == CMD_WRITE) begin
                        r_res_spin <= r_spin_in;
                        r_state    <= S_RESP;
                    end else begin
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    r_rd_pend <= nbr_valid;
                    r_rd_k    <= r_k;
                    r_k       <= n_k;
                    if ((r_cmd == CMD_READ) || (r_k == STEP_ZM)) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    r_state <= S_LOOKUP;
                end
                S_LOOKUP: begin
                    if (r_cmd == CMD_READ) begin
                        r_res_spin <= r_self;
                        r_state    <= S_RESP;
                    end else begin
                        r_state <= S_DECIDE;
                    end
                end
                S_DECIDE: begin
                    r_res_spin <= r_self ^ flip;
                    r_res_flip <= flip;
                    r_state    <= S_RESP;
                end
                S_RESP: begin
                    if (!r_out_valid || i_m_tready) begin
                        r_out_valid  <= 1'b1;
                        r_out_spin   <= r_res_spin;
                        r_out_flip   <= r_res_flip;
                        r_out_sum    <= r_sum;
                        r_out_status <= r_res_status;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    a_flip_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_flip) |-> (r_out_status == ST_OK))
        else $error("flip reported with non-ok status");

    a_sum_only_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_sum != '0)) |-> (r_out_status == ST_OK))
        else $error("neighbour sum reported with non-ok status");

    a_sum_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (($signed(r_out_sum) <= 4'sd6) && ($signed(r_out_sum) >= -4'sd6)))
        else $error("neighbour sum out of range");

    a_resp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_RESP) && r_out_valid && !i_m_tready) |=> (r_state == S_RESP))
        else $error("result dropped while output stalled");

endmodule
